// ===== sv/sm2_pkg.sv =====
// Shared types and constants for the SM2 prime field arithmetic unit.
`default_nettype none
package sm2_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned NumCells = 8;

  localparam logic [255:0] Prime =
    256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_FFFFFFFF_FFFFFFFF;

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActNeg = 2'd2,
    ActMul = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] operand_a_limb0;
    logic [63:0] operand_a_limb1;
    logic [63:0] operand_a_limb2;
    logic [63:0] operand_a_limb3;
    logic [63:0] operand_b_limb0;
    logic [63:0] operand_b_limb1;
    logic [63:0] operand_b_limb2;
    logic [63:0] operand_b_limb3;
  } sm2_in_t;

  typedef struct packed {
    logic [63:0] result_limb0;
    logic [63:0] result_limb1;
    logic [63:0] result_limb2;
    logic [63:0] result_limb3;
  } sm2_out_t;

  // Word travelling down the chain of cells.
  typedef struct packed {
    logic         vld;
    logic [1:0]   action;
    logic [255:0] a;
    logic [255:0] b;
    logic [255:0] r;     // plain result, or running Montgomery accumulator
    logic         top;   // bit 256 of the accumulator
  } sm2_word_t;

endpackage
`default_nettype wire

// ===== sv/sm2_cell.sv =====
// One Montgomery cell: folds one 32-bit word of a into the accumulator.
`default_nettype none
module sm2_cell
  import sm2_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sm2_word_t w_i,
  output sm2_word_t      w_o
);

  logic [31:0]  ai;
  logic [287:0] prod_d, prod_q;
  sm2_word_t    mid_q;
  logic [289:0] acc;
  logic [31:0]  u;
  logic [289:0] sum;

  assign ai = w_i.a[Idx*32 +: 32];

  // Stage 1: multiply a word of a by b (32 x 256, as eight 32x32 products).
  always_comb begin
    prod_d = '0;
    for (int j = 0; j < NumWords; j++) begin
      prod_d = prod_d + (288'(64'(ai) * 64'(w_i.b[j*32 +: 32])) << (j*32));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else begin
      mid_q <= w_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Stage 2: accumulate, then add u*p and shift one word (mu = 1).
  // u*p = u*2^256 - u*2^224 - u*2^96 + u*2^64 - u.
  always_comb begin
    acc = 290'({mid_q.top, mid_q.r}) + 290'(prod_q);
    u   = acc[31:0];
    sum = acc + (290'(u) << 256) + (290'(u) << 64)
          - (290'(u) << 224) - (290'(u) << 96) - 290'(u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_o <= '0;
    end else begin
      w_o.vld    <= mid_q.vld;
      w_o.action <= mid_q.action;
      w_o.a      <= mid_q.a;
      w_o.b      <= mid_q.b;
      if (mid_q.action == ActMul) begin
        w_o.r   <= sum[287:32];
        w_o.top <= sum[288];
      end else begin
        w_o.r   <= mid_q.r;
        w_o.top <= mid_q.top;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sm2_prime_field_alu_unit.sv =====
// Top level: SM2 prime field add, subtract, negate and Montgomery multiply.
// Every action passes the input register, both registers of each cell and the done_o register.
// Throughput: one word per cycle; busy is always low.
// Multiply runs through a chain of eight cells, two stages each; the
// other actions ride along in the same chain. Reset clears the chain and done_o.
`default_nettype none
module sm2_prime_field_alu_unit
  import sm2_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire sm2_in_t in_i,
  output logic         done_o,
  output sm2_out_t     out_o
);

  sm2_word_t w_d, w_q;
  sm2_word_t chain [NumCells+1];
  logic [255:0] a, b, s, d, n, fin;
  logic         sc, db, fin_ge;
  logic [256:0] add_s;
  logic [256:0] sub_d;
  logic [255:0] corr;

  assign busy = 1'b0;
  assign a = {in_i.operand_a_limb3, in_i.operand_a_limb2,
              in_i.operand_a_limb1, in_i.operand_a_limb0};
  assign b = {in_i.operand_b_limb3, in_i.operand_b_limb2,
              in_i.operand_b_limb1, in_i.operand_b_limb0};

  // Plain actions finish here; multiply starts with a zero accumulator.
  always_comb begin
    add_s = {1'b0, a} + {1'b0, b};
    sc    = add_s[256] || (add_s[255:0] >= Prime);
    s     = sc ? add_s[255:0] - Prime : add_s[255:0];
    sub_d = {1'b0, a} - {1'b0, b};
    db    = sub_d[256];
    d     = db ? sub_d[255:0] + Prime : sub_d[255:0];
    n     = (a == '0) ? '0 : Prime - a;
    w_d.vld    = start;
    w_d.action = in_i.action;
    w_d.a      = a;
    w_d.b      = b;
    w_d.top    = 1'b0;
    unique case (action_e'(in_i.action))
      ActAdd:  w_d.r = s;
      ActSub:  w_d.r = d;
      ActNeg:  w_d.r = n;
      default: w_d.r = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q <= w_d;
    end
  end

  assign chain[0] = w_q;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sm2_cell #(.Idx(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .w_i   (chain[g]),
      .w_o   (chain[g+1])
    );
  end

  // Final conditional subtraction for multiply.
  always_comb begin
    fin_ge = chain[NumCells].top || (chain[NumCells].r >= Prime);
    corr   = chain[NumCells].r - Prime;
    if (chain[NumCells].action == ActMul && fin_ge) begin
      fin = corr;
    end else begin
      fin = chain[NumCells].r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= chain[NumCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= {fin[63:0], fin[127:64], fin[191:128], fin[255:192]};
  end

endmodule
`default_nettype wire

// ===== sv/sm2_checker.sv =====
// Port-level checker for the SM2 field unit, bound to the top level.
`default_nettype none
module sm2_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start ##18 1'b1 |-> !done_o) else $error("result without start");

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##18 done_o) else $error("result lost");

endmodule

bind sm2_prime_field_alu_unit sm2_checker u_sm2_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o)
);
`default_nettype wire
